[sv/keyword_identifier_tokenizer_defines.svh]
// Assertion macros for the keyword/identifier tokenizer.
// Used by the top level; no other dependencies.
`ifndef KEYWORD_IDENTIFIER_TOKENIZER_DEFINES_SVH
`define KEYWORD_IDENTIFIER_TOKENIZER_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset.
`define KIT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, disabled during reset.
`define KIT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);
`else
`define KIT_ASSERT_IMP(label, clk, rst, ante, cons, msg)
`define KIT_ASSERT_NXT(label, clk, rst, ante, cons, msg)
`endif
`endif

[sv/kit_pkg.sv]
// Shared types, constants and keyword table for the keyword/identifier tokenizer.
// No dependencies.
package kit_pkg;

  localparam int MAX_WORD_LEN_DEF  = 64;
  localparam int KEYWORD_COUNT_DEF = 19;
  localparam int QUEUE_DEPTH_DEF   = 4;

  localparam int KW_TABLE_SIZE = 19;
  localparam int KW_MAXLEN     = 8;

  localparam int INDEX_W  = 5;
  localparam int LENGTH_W = 7;
  localparam int OFFSET_W = 32;

  // Token kind codes.
  localparam logic TK_KEYWORD = 1'b0;
  localparam logic TK_IDENT   = 1'b1;

  // Work codes passed from the front to the back.
  typedef enum logic [1:0] {
    OP_START,
    OP_CHAR,
    OP_END
  } op_t;

  typedef struct packed {
    op_t                 op;
    logic [7:0]          ch;
    logic [OFFSET_W-1:0] offset;
  } entry_t;

  typedef struct packed {
    logic full;
    logic empty;
  } qstat_t;

  // Keyword lengths and texts, right-justified, first character most significant.
  localparam logic [3:0] KW_LEN [KW_TABLE_SIZE] = '{
    4'd4, 4'd5, 4'd4, 4'd4, 4'd3, 4'd6, 4'd5, 4'd6, 4'd8, 4'd4,
    4'd4, 4'd5, 4'd6, 4'd6, 4'd8, 4'd7, 4'd2, 4'd4, 4'd2
  };

  localparam logic [8*KW_MAXLEN-1:0] KW_TEXT [KW_TABLE_SIZE] = '{
    "auto", "break", "case", "char", "int", "double", "float", "signed",
    "unsigned", "void", "enum", "const", "extern", "static", "continue",
    "default", "do", "else", "if"
  };

  // Character of keyword k at position pos, zero past the keyword's end.
  function automatic logic [7:0] kw_char(input int k, input logic [2:0] pos);
    logic [8*KW_MAXLEN-1:0] text;
    logic [8*KW_MAXLEN-1:0] sh;
    int                     len;
    logic [7:0]             res;
    text = KW_TEXT[k];
    len  = int'(KW_LEN[k]);
    sh   = '0;
    res  = '0;
    for (int i = 0; i < KW_MAXLEN; i++) begin
      if (3'(i) == pos && i < len) begin
        sh  = text >> (8 * (len - 1 - i));
        res = sh[7:0];
      end
    end
    return res;
  endfunction

endpackage

[sv/keyword_identifier_tokenizer.sv]
// Keyword/identifier tokenizer top level: front, work queue, back; uses kit_pkg.
// Throughput: one byte accepted per cycle while the queue has room; the back drains one queue entry
// a cycle, except that a word end waits while the output register holds a stalled token.
// Path: a word's ending byte is written into the queue, then popped and loaded into the output register.
// Stalls: input stalls only while the queue is full, i.e. a token waits on a stalled output.
// Reset (synchronous): word state, stream offset, queue and output valid cleared.
`include "keyword_identifier_tokenizer_defines.svh"
module keyword_identifier_tokenizer #(
  parameter int MAX_WORD_LEN  = kit_pkg::MAX_WORD_LEN_DEF,
  parameter int KEYWORD_COUNT = kit_pkg::KEYWORD_COUNT_DEF,
  parameter int QUEUE_DEPTH   = kit_pkg::QUEUE_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    ch,
  input  logic                          end_of_stream,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          token_kind,
  output logic [kit_pkg::INDEX_W-1:0]   keyword_index,
  output logic [kit_pkg::LENGTH_W-1:0]  word_length,
  output logic [kit_pkg::OFFSET_W-1:0]  word_start,
  output logic                          too_long
);

  kit_pkg::qstat_t qstat;
  kit_pkg::entry_t push_entry;
  kit_pkg::entry_t head;
  logic            push;
  logic            pop;

  kit_front u_front (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .ch            (ch),
    .end_of_stream (end_of_stream),
    .qstat         (qstat),
    .push          (push),
    .push_entry    (push_entry)
  );

  kit_fifo #(
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_entry (push_entry),
    .pop        (pop),
    .head       (head),
    .qstat      (qstat)
  );

  kit_back #(
    .MAX_WORD_LEN  (MAX_WORD_LEN),
    .KEYWORD_COUNT (KEYWORD_COUNT)
  ) u_back (
    .clk           (clk),
    .rst           (rst),
    .head          (head),
    .qstat         (qstat),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .token_kind    (token_kind),
    .keyword_index (keyword_index),
    .word_length   (word_length),
    .word_start    (word_start),
    .too_long      (too_long)
  );

  // The front never writes a full queue.
  `KIT_ASSERT_IMP(a_no_push_full, clk, rst, push, !qstat.full, "queue written while full")
  // A word end taken from the queue head becomes a token.
  `KIT_ASSERT_NXT(a_end_drains, clk, rst, pop && head.op == kit_pkg::OP_END, out_valid, "word end lost")
  // An overlong word is never reported as a keyword.
  `KIT_ASSERT_IMP(a_kw_not_long, clk, rst, out_valid && token_kind == kit_pkg::TK_KEYWORD, !too_long, "keyword token flagged too long")
  // Identifiers carry a zero keyword index.
  `KIT_ASSERT_IMP(a_ident_index, clk, rst, out_valid && token_kind == kit_pkg::TK_IDENT, keyword_index == '0, "identifier with nonzero index")

endmodule

[sv/kit_front.sv]
// Front end of the tokenizer: accepts bytes, classifies them and queues work.
// Depends on kit_pkg.
module kit_front (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [7:0]                    ch,
  input  logic                          end_of_stream,
  input  kit_pkg::qstat_t               qstat,
  output logic                          push,
  output kit_pkg::entry_t               push_entry
);

  logic                          in_word;
  logic                          in_word_next;
  logic [kit_pkg::OFFSET_W-1:0]  stream_offset;
  logic [kit_pkg::OFFSET_W-1:0]  stream_offset_next;
  logic                          accept;
  logic                          word_byte;

  // The front holds off only when the queue has no room.
  assign in_stall = qstat.full;
  assign accept   = in_valid && !in_stall;

  assign word_byte = (ch >= 8'h41 && ch <= 8'h5A) || (ch >= 8'h61 && ch <= 8'h7A) ||
                     (ch == 8'h5F);

  // Classify the request and decide what goes into the queue.
  always_comb begin
    in_word_next       = in_word;
    stream_offset_next = stream_offset;
    push               = 1'b0;
    push_entry.op      = kit_pkg::OP_END;
    push_entry.ch      = ch;
    push_entry.offset  = stream_offset;
    if (accept) begin
      priority if (end_of_stream) begin
        push         = in_word;
        in_word_next = 1'b0;
      end else if (word_byte) begin
        push               = 1'b1;
        push_entry.op      = in_word ? kit_pkg::OP_CHAR : kit_pkg::OP_START;
        in_word_next       = 1'b1;
        stream_offset_next = stream_offset + 1'b1;
      end else begin
        push               = in_word;
        in_word_next       = 1'b0;
        stream_offset_next = stream_offset + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_word       <= 1'b0;
      stream_offset <= '0;
    end else begin
      in_word       <= in_word_next;
      stream_offset <= stream_offset_next;
    end
  end

endmodule

[sv/kit_fifo.sv]
// Short work queue between the tokenizer front and back.
// Depends on kit_pkg.
module kit_fifo #(
  parameter int DEPTH = kit_pkg::QUEUE_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            push,
  input  kit_pkg::entry_t push_entry,
  input  logic            pop,
  output kit_pkg::entry_t head,
  output kit_pkg::qstat_t qstat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  kit_pkg::entry_t  slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign head        = slots[rd_ptr];
  assign qstat.full  = (count == CNT_W'(DEPTH));
  assign qstat.empty = (count == '0);

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_entry;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/kit_back.sv]
// Back end of the tokenizer: narrows the keyword mask and builds tokens.
// Depends on kit_pkg; holds the output register.
module kit_back #(
  parameter int MAX_WORD_LEN  = kit_pkg::MAX_WORD_LEN_DEF,
  parameter int KEYWORD_COUNT = kit_pkg::KEYWORD_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst,
  input  kit_pkg::entry_t               head,
  input  kit_pkg::qstat_t               qstat,
  output logic                          pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          token_kind,
  output logic [kit_pkg::INDEX_W-1:0]   keyword_index,
  output logic [kit_pkg::LENGTH_W-1:0]  word_length,
  output logic [kit_pkg::OFFSET_W-1:0]  word_start,
  output logic                          too_long
);

  localparam int NACT = (KEYWORD_COUNT < kit_pkg::KW_TABLE_SIZE) ?
                        KEYWORD_COUNT : kit_pkg::KW_TABLE_SIZE;
  localparam int LS_W = $clog2(MAX_WORD_LEN + 1);
  localparam logic [LS_W-1:0] LS_MAX = LS_W'(MAX_WORD_LEN);

  logic [LS_W-1:0]              letters_seen;
  logic [LS_W-1:0]              letters_seen_next;
  logic [NACT-1:0]              candidate_mask;
  logic [NACT-1:0]              candidate_mask_next;
  logic                         overflowed;
  logic                         overflowed_next;
  logic [kit_pkg::OFFSET_W-1:0] start_offset;
  logic [kit_pkg::OFFSET_W-1:0] start_offset_next;

  logic [LS_W-1:0]              base_len;
  logic [NACT-1:0]              base_mask;
  logic                         base_ovf;
  logic [NACT-1:0]              keep;
  logic                         hit;
  logic [kit_pkg::INDEX_W-1:0]  hit_index;
  logic                         out_free;
  logic                         emit;

  assign out_free = !out_valid || !out_stall;
  assign pop      = !qstat.empty && (head.op != kit_pkg::OP_END || out_free);
  assign emit     = pop && (head.op == kit_pkg::OP_END);

  // A word's first byte starts from a fresh mask and count.
  assign base_len  = (head.op == kit_pkg::OP_START) ? '0 : letters_seen;
  assign base_mask = (head.op == kit_pkg::OP_START) ? '1 : candidate_mask;
  assign base_ovf  = (head.op == kit_pkg::OP_START) ? 1'b0 : overflowed;

  // Per-keyword compare of the incoming byte at the current position.
  always_comb begin
    for (int k = 0; k < NACT; k++) begin
      keep[k] = (base_len < LS_W'(kit_pkg::KW_LEN[k])) &&
                (kit_pkg::kw_char(k, base_len[2:0]) == head.ch);
    end
  end

  // Lowest surviving keyword whose length equals the word length.
  always_comb begin
    hit       = 1'b0;
    hit_index = '0;
    for (int k = NACT - 1; k >= 0; k--) begin
      if (candidate_mask[k] && letters_seen == LS_W'(kit_pkg::KW_LEN[k])) begin
        hit       = 1'b1;
        hit_index = kit_pkg::INDEX_W'(k);
      end
    end
  end

  // Word state update for the entry at the queue head.
  always_comb begin
    letters_seen_next   = letters_seen;
    candidate_mask_next = candidate_mask;
    overflowed_next     = overflowed;
    start_offset_next   = start_offset;
    if (pop) begin
      unique case (head.op)
        kit_pkg::OP_START, kit_pkg::OP_CHAR: begin
          if (head.op == kit_pkg::OP_START) begin
            start_offset_next = head.offset;
          end
          if (base_len < LS_MAX) begin
            letters_seen_next   = base_len + 1'b1;
            candidate_mask_next = base_mask & keep;
            overflowed_next     = base_ovf;
          end else begin
            letters_seen_next   = base_len;
            candidate_mask_next = base_mask;
            overflowed_next     = 1'b1;
          end
        end
        kit_pkg::OP_END: begin
          letters_seen_next   = '0;
          candidate_mask_next = '1;
          overflowed_next     = 1'b0;
        end
        default: begin
          letters_seen_next = letters_seen;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      letters_seen   <= '0;
      candidate_mask <= '1;
      overflowed     <= 1'b0;
      start_offset   <= '0;
    end else begin
      letters_seen   <= letters_seen_next;
      candidate_mask <= candidate_mask_next;
      overflowed     <= overflowed_next;
      start_offset   <= start_offset_next;
    end
  end

  // Output register: holds a token until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      token_kind    <= (!overflowed && hit) ? kit_pkg::TK_KEYWORD : kit_pkg::TK_IDENT;
      keyword_index <= (!overflowed && hit) ? hit_index : '0;
      word_length   <= kit_pkg::LENGTH_W'(letters_seen);
      word_start    <= start_offset;
      too_long      <= overflowed;
    end
  end

endmodule
